@@ rtl/sbpf_pkg.sv @@
// sbpf_pkg: shared types and constants for the sample burst packet framer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package sbpf_pkg;

  localparam int PAYLOAD_BYTES = 504;
  localparam int PKT_SAMPLES   = PAYLOAD_BYTES / 4;
  localparam int PKT_W         = $clog2(PKT_SAMPLES + 1);

  localparam logic [4:0] CHAN_CONTROL = 5'h1f;
  localparam logic [4:0] CHAN_DATA    = 5'h00;

  typedef logic [PKT_W-1:0] slot_t;

  typedef enum logic [1:0] {
    KIND_HDR     = 2'd0,
    KIND_TIME    = 2'd1,
    KIND_PAYLOAD = 2'd2
  } word_kind_e;

  typedef struct packed {
    logic               first_of_burst;
    logic [15:0]        burst_samples;
    logic [31:0]        start_time;
    logic               control_burst;
    logic signed [15:0] sample_i;
    logic signed [15:0] sample_q;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_word;
    word_kind_e  word_kind;
    logic        packet_end;
    logic        burst_end;
    logic        run_last;
  } out_item_t;

  // words produced by one input beat: optional header and timestamp, then payload
  typedef struct packed {
    logic        has_hdr;
    logic [31:0] hdr_word;
    logic [31:0] time_word;
    logic [31:0] pay_word;
    logic        packet_end;
    logic        burst_end;
  } group_t;

endpackage

@@ rtl/sbpf_framer.sv @@
// sbpf_framer: burst and packet state, builds the word group for each beat
// depends on sbpf_pkg
`timescale 1ns / 1ps

module sbpf_framer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  sbpf_pkg::in_item_t in_i,
  output logic              produce_o,
  output sbpf_pkg::group_t  grp_o
);

  localparam logic [15:0] PktLen16 = 16'(sbpf_pkg::PKT_SAMPLES);
  localparam sbpf_pkg::slot_t PktLen = sbpf_pkg::slot_t'(sbpf_pkg::PKT_SAMPLES);

  logic [15:0]     samples_left_q, samples_left_d;
  sbpf_pkg::slot_t slot_q, slot_d;
  sbpf_pkg::slot_t packet_samples_q, packet_samples_d;
  logic [31:0]     packet_time_q, packet_time_d;
  logic            control_kind_q, control_kind_d;
  logic            start_pending_q, start_pending_d;

  logic [15:0]     sl, sl_dec;
  sbpf_pkg::slot_t slot, ps, pkt, cur_pkt, slot_inc;
  logic [31:0]     ptime;
  logic            kind, pending, active, pkt_open, is_end, pend, bend;
  logic [4:0]      chan;
  logic [15:0]     byte_cnt;

  always_comb begin
    // a first beat loads the burst before the beat itself is framed
    if (in_i.first_of_burst) begin
      sl      = in_i.burst_samples;
      ptime   = in_i.start_time;
      kind    = in_i.control_burst;
      pending = 1'b1;
      slot    = '0;
      ps      = '0;
    end else begin
      sl      = samples_left_q;
      ptime   = packet_time_q;
      kind    = control_kind_q;
      pending = start_pending_q;
      slot    = slot_q;
      ps      = packet_samples_q;
    end

    active   = (sl != 16'd0);
    pkt_open = (slot == '0);
    is_end   = (sl <= PktLen16);
    pkt      = (sl < PktLen16) ? sbpf_pkg::slot_t'(sl) : PktLen;
    chan     = kind ? sbpf_pkg::CHAN_CONTROL : sbpf_pkg::CHAN_DATA;
    byte_cnt = 16'({pkt, 2'b00});
    cur_pkt  = pkt_open ? pkt : ps;
    slot_inc = slot + sbpf_pkg::slot_t'(1);
    sl_dec   = sl - 16'd1;
    pend     = (slot_inc >= cur_pkt);
    bend     = (sl_dec == 16'd0);

    grp_o.has_hdr    = pkt_open;
    grp_o.hdr_word   = {3'b000, pending, is_end, 6'b000000, chan, byte_cnt};
    grp_o.time_word  = ptime;
    grp_o.pay_word   = {in_i.sample_q, in_i.sample_i};
    grp_o.packet_end = pend | bend;
    grp_o.burst_end  = bend;

    produce_o = accept_i & active;

    samples_left_d   = active ? sl_dec : sl;
    slot_d           = (active && !(pend || bend)) ? slot_inc : (active ? '0 : slot);
    packet_samples_d = (active && pkt_open) ? pkt : ps;
    packet_time_d    = (active && pkt_open) ? ptime + 32'(pkt) : ptime;
    start_pending_d  = (active && pkt_open) ? 1'b0 : pending;
    control_kind_d   = kind;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_left_q   <= '0;
      slot_q           <= '0;
      packet_samples_q <= '0;
      packet_time_q    <= '0;
      control_kind_q   <= 1'b0;
      start_pending_q  <= 1'b0;
    end else if (accept_i) begin
      samples_left_q   <= samples_left_d;
      slot_q           <= slot_d;
      packet_samples_q <= packet_samples_d;
      packet_time_q    <= packet_time_d;
      control_kind_q   <= control_kind_d;
      start_pending_q  <= start_pending_d;
    end
  end

  // inside a packet the slot count never reaches the packet size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (samples_left_q != 16'd0 && slot_q != '0) |-> (slot_q < packet_samples_q))
    else $error("slot count past packet size");

  // a payload word that ends the burst also closes its packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && active && bend) |=> (slot_q == '0 && samples_left_q == 16'd0))
    else $error("burst end left packet open");

endmodule

@@ rtl/sbpf_serializer.sv @@
// sbpf_serializer: holds one word group and sends it one word per beat
// depends on sbpf_pkg
`timescale 1ns / 1ps

module sbpf_serializer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  sbpf_pkg::group_t    grp_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sbpf_pkg::out_item_t out_data_o
);

  sbpf_pkg::group_t     grp_q;
  logic                 grp_valid_q;
  sbpf_pkg::word_kind_e pos_q, pos_d;
  logic                 last, take;

  assign last        = (pos_q == sbpf_pkg::KIND_PAYLOAD);
  assign out_valid_o = grp_valid_q;
  assign take        = grp_valid_q & out_ready_i;
  // group slot frees up as its payload word leaves
  assign free_o      = !grp_valid_q || (take && last);

  always_comb begin
    case (pos_q)
      sbpf_pkg::KIND_HDR:  pos_d = sbpf_pkg::KIND_TIME;
      sbpf_pkg::KIND_TIME: pos_d = sbpf_pkg::KIND_PAYLOAD;
      default:             pos_d = sbpf_pkg::KIND_PAYLOAD;
    endcase
  end

  always_comb begin
    case (pos_q)
      sbpf_pkg::KIND_HDR:  out_data_o.out_word = grp_q.hdr_word;
      sbpf_pkg::KIND_TIME: out_data_o.out_word = grp_q.time_word;
      default:             out_data_o.out_word = grp_q.pay_word;
    endcase
    out_data_o.word_kind  = pos_q;
    out_data_o.packet_end = last & grp_q.packet_end;
    out_data_o.burst_end  = last & grp_q.burst_end;
    out_data_o.run_last   = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_valid_q <= 1'b0;
      pos_q       <= sbpf_pkg::KIND_PAYLOAD;
    end else if (load_i) begin
      grp_valid_q <= 1'b1;
      pos_q       <= grp_i.has_hdr ? sbpf_pkg::KIND_HDR : sbpf_pkg::KIND_PAYLOAD;
    end else if (take) begin
      if (last) begin
        grp_valid_q <= 1'b0;
      end else begin
        pos_q <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("group loaded over a pending group");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !last && !load_i) |=> (out_valid_o && pos_q != $past(pos_q)))
    else $error("group word sequence did not advance");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && last && !load_i) |=> !out_valid_o)
    else $error("group still valid after its last word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (out_valid_o && (pos_q == sbpf_pkg::KIND_HDR ||
                                pos_q == sbpf_pkg::KIND_PAYLOAD)))
    else $error("group started on a timestamp word");

endmodule

@@ rtl/sample_burst_packet_framer.sv @@
// sample_burst_packet_framer: top level, cuts sample bursts into packets
// depends on sbpf_pkg, sbpf_framer, sbpf_serializer
// latency: the first word of a beat's results is shown the cycle after acceptance
// inside a packet a new beat is taken as the prior payload word leaves; a beat
//   opening a packet first sends header and timestamp words from the group register
// reset clears the burst state: no burst active, timestamp and kind zero
`timescale 1ns / 1ps

module sample_burst_packet_framer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sbpf_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sbpf_pkg::out_item_t out_data_o
);

  logic             accept, produce, free;
  sbpf_pkg::group_t grp;

  assign in_ready_o = free;
  assign accept     = in_valid_i & free;

  sbpf_framer u_framer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_i      (in_data_i),
    .produce_o (produce),
    .grp_o     (grp)
  );

  sbpf_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (produce),
    .grp_i       (grp),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
